// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the generator top.
// ----------------------------------------------------------------------------
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XS_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== design/xs64_pkg.sv =====
// ----------------------------------------------------------------------------
// xs64_pkg
// Shared types, constants and helper functions for the xorshift64* generator.
// ----------------------------------------------------------------------------
package xs64_pkg;

  localparam logic [63:0] GOLDEN  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_B   = 64'h94D049BB133111EB;
  localparam logic [63:0] OUT_MUL = 64'h2545F4914F6CDD1D;

  // The multiplier runs three partial products; this is the index of the last.
  localparam logic [1:0] MUL_STEP_LAST = 2'd2;

  typedef enum logic [1:0] {
    KIND_DRAW = 2'd0,
    KIND_SEED = 2'd1,
    KIND_LOAD = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED1,
    ST_SEED2,
    ST_DRAW,
    ST_DONE
  } state_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // Response from the shared multiplier.
  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  // First splitmix64 stage: add the golden ratio and fold down by 30.
  function automatic logic [63:0] seed_pre(input logic [31:0] s);
    logic [63:0] z;
    z = {32'd0, s} + GOLDEN;
    return z ^ (z >> 30);
  endfunction

  // One xorshift64 step.
  function automatic logic [63:0] xs_step(input logic [63:0] x);
    logic [63:0] y;
    y = x ^ (x >> 12);
    y = y ^ (y << 25);
    y = y ^ (y >> 27);
    return y;
  endfunction

endpackage

// ===== design/xs64_mul.sv =====
// ----------------------------------------------------------------------------
// xs64_mul
// Shared 64 x 64 multiplier, low 64 bits of the product, built from one
// 32 x 32 multiplier in three passes.
// ----------------------------------------------------------------------------
module xs64_mul (
  input  logic               clk,
  input  logic               rst,
  input  xs64_pkg::mul_req_t req,
  output xs64_pkg::mul_rsp_t rsp
);

  logic [63:0] a_op;
  logic [63:0] b_op;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        busy;
  logic        done;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  // Low x low first, then the two cross terms that land in the upper half.
  always_comb begin
    case (step)
      2'd0: begin
        mul_a = a_op[31:0];
        mul_b = b_op[31:0];
      end
      2'd1: begin
        mul_a = a_op[63:32];
        mul_b = b_op[31:0];
      end
      default: begin
        mul_a = a_op[31:0];
        mul_b = b_op[63:32];
      end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == xs64_pkg::MUL_STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_op <= req.a;
      b_op <= req.b;
    end
    if (busy) begin
      if (step == 2'd0) begin
        acc <= prod;
      end else begin
        acc[63:32] <= acc[63:32] + prod[31:0];
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

// ===== design/xorshift64_star_generator_top.sv =====
// ----------------------------------------------------------------------------
// xorshift64_star_generator_top
// xorshift64* random source with splitmix64 seeding, one result per request.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ------------------------------------------
//   in       in_valid / in_ready  kind, seed_value, state_word
//   out      out_valid/out_ready  random_value, state_report, is_seeded
//
// A request is taken only while the sequencer is idle. Load and the unused
// kind run no multiply; a draw from a seeded state runs one, a seed two and
// a draw from an unseeded state three. Each 64-bit multiply is three passes
// through the single 32 x 32 multiplier. Reset clears the state, the seeded
// flag and out_valid, which leaves in_ready high. When the output register
// is still held by a stalled consumer, the finished result waits in the done
// state.
//
module xorshift64_star_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] seed_value,
  input  logic [63:0] state_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] random_value,
  output logic [63:0] state_report,
  output logic        is_seeded
);

  `include "assert_macros.svh"

  xs64_pkg::state_t   state;
  xs64_pkg::state_t   state_next;
  xs64_pkg::mul_req_t mul_req;
  xs64_pkg::mul_rsp_t mul_rsp;

  // Generator state and the value produced for the current request.
  logic [63:0] gen_state;
  logic [63:0] gen_state_next;
  logic        seeded;
  logic        seeded_next;
  logic [31:0] value;
  logic [31:0] value_next;
  // Set when a draw found the generator unseeded and must seed first.
  logic        draw_pend;
  logic        draw_pend_next;
  logic        out_valid_next;

  logic [63:0] prod;
  logic [63:0] mix1;
  logic [63:0] mix2;
  logic [63:0] seed_st;
  logic [63:0] draw_x;

  xs64_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // Splitmix64 folds that follow the two seeding multiplies, and the xorshift step that
  // feeds the output multiply. The step works on the freshly seeded state
  // when a draw had to seed first.
  assign prod    = mul_rsp.product;
  assign mix1    = prod ^ (prod >> 27);
  assign mix2    = prod ^ (prod >> 31);
  assign seed_st = (mix2 == 64'd0) ? xs64_pkg::GOLDEN : mix2;
  assign draw_x  = xs64_pkg::xs_step((state == xs64_pkg::ST_SEED2) ? seed_st : gen_state);

  assign in_ready = (state == xs64_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    gen_state_next = gen_state;
    seeded_next    = seeded;
    value_next     = value;
    draw_pend_next = draw_pend;
    out_valid_next = out_valid && !out_ready;
    mul_req        = '0;

    unique case (state)
      xs64_pkg::ST_IDLE: begin
        if (in_valid) begin
          value_next     = 32'd0;
          draw_pend_next = 1'b0;
          case (kind)
            xs64_pkg::KIND_DRAW: begin
              if (seeded) begin
                gen_state_next = draw_x;
                mul_req.start  = 1'b1;
                mul_req.a      = draw_x;
                mul_req.b      = xs64_pkg::OUT_MUL;
                state_next     = xs64_pkg::ST_DRAW;
              end else begin
                // Unseeded draw: seed with zero first.
                draw_pend_next = 1'b1;
                mul_req.start  = 1'b1;
                mul_req.a      = xs64_pkg::seed_pre(32'd0);
                mul_req.b      = xs64_pkg::MIX_A;
                state_next     = xs64_pkg::ST_SEED1;
              end
            end
            xs64_pkg::KIND_SEED: begin
              mul_req.start = 1'b1;
              mul_req.a     = xs64_pkg::seed_pre(seed_value);
              mul_req.b     = xs64_pkg::MIX_A;
              state_next    = xs64_pkg::ST_SEED1;
            end
            xs64_pkg::KIND_LOAD: begin
              gen_state_next = state_word;
              seeded_next    = |state_word;
              state_next     = xs64_pkg::ST_DONE;
            end
            default: begin
              state_next = xs64_pkg::ST_DONE;
            end
          endcase
        end
      end
      xs64_pkg::ST_SEED1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mix1;
          mul_req.b     = xs64_pkg::MIX_B;
          state_next    = xs64_pkg::ST_SEED2;
        end
      end
      xs64_pkg::ST_SEED2: begin
        if (mul_rsp.done) begin
          seeded_next = 1'b1;
          if (draw_pend) begin
            gen_state_next = draw_x;
            mul_req.start  = 1'b1;
            mul_req.a      = draw_x;
            mul_req.b      = xs64_pkg::OUT_MUL;
            state_next     = xs64_pkg::ST_DRAW;
          end else begin
            gen_state_next = seed_st;
            state_next     = xs64_pkg::ST_DONE;
          end
        end
      end
      xs64_pkg::ST_DRAW: begin
        if (mul_rsp.done) begin
          value_next = prod[63:32];
          state_next = xs64_pkg::ST_DONE;
        end
      end
      xs64_pkg::ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          state_next     = xs64_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = xs64_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xs64_pkg::ST_IDLE;
      gen_state <= 64'd0;
      seeded    <= 1'b0;
      draw_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      gen_state <= gen_state_next;
      seeded    <= seeded_next;
      draw_pend <= draw_pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Result payload; loaded only as the done state hands over a result.
  always_ff @(posedge clk) begin
    value <= value_next;
    if (state == xs64_pkg::ST_DONE && (!out_valid || out_ready)) begin
      random_value <= value;
      state_report <= seeded ? gen_state : 64'd0;
      is_seeded    <= seeded;
    end
  end

  // The multiplier only reports back while a multiply is outstanding.
  `XS_ASSERT_SAME(a_idle_no_mul, state == xs64_pkg::ST_IDLE, !mul_rsp.done, "multiplier done while idle")
  // A seeded generator never holds the all-zero state.
  `XS_ASSERT_SAME(a_seeded_nonzero, seeded, gen_state != 64'd0, "seeded with zero state")
  // An unseeded result reports a zero state.
  `XS_ASSERT_SAME(a_report_zero, out_valid && !is_seeded, state_report == 64'd0, "unseeded state leaked")
  // Only one request is in work at a time.
  `XS_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule
